FILE: design/afs_pkg.sv
// Shared widths, command codes and bundle types of the animation frame sequencer.
`default_nettype none

package afs_pkg;

    // Table and field widths
    localparam int FRAMES  = 64;
    localparam int IDX_W   = $clog2(FRAMES);
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int DUR_W   = 16;
    localparam int PASS_W  = 16;
    localparam int TIME_W  = 32;
    localparam int LOOP_W  = 17;
    localparam int VT_W    = DUR_W + IDX_W;
    localparam int CMD_W   = 3;
    localparam int STEP_W  = $clog2(TIME_W);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_APPEND = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_UPDATE = CMD_W'(2);
    localparam logic [CMD_W-1:0] CMD_SET    = CMD_W'(3);
    localparam logic [CMD_W-1:0] CMD_CLEAR  = CMD_W'(4);

    // Shared adder operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [DUR_W-1:0] len;
        logic             vis;
    } t_frame;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_frame           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  frame_index;
        logic [DUR_W-1:0]  duration;
        logic              visible;
        logic [PASS_W-1:0] time_passed;
    } t_request;

    typedef struct packed {
        logic             accepted;
        logic [IDX_W-1:0] current_frame;
        logic             frame_shown;
        logic [IDX_W-1:0] slot_index;
    } t_result;

endpackage

`default_nettype wire

FILE: design/animation_frame_sequencer_top.sv
// Animation frame sequencer top: handshakes, loop-limit register and output register.
// A tick checks up to 63 other table entries for each frame advance and may fold the time by a remainder.
// One request at a time: ready drops at acceptance until the result moves to the output.
// Synchronous active-low reset empties the table state and sets the loop limit to endless.
`default_nettype none

module animation_frame_sequencer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [afs_pkg::CMD_W-1:0]         i_command,
    input  logic [afs_pkg::IDX_W-1:0]         i_frame_index,
    input  logic [afs_pkg::DUR_W-1:0]         i_duration,
    input  logic                              i_visible,
    input  logic [afs_pkg::PASS_W-1:0]        i_time_passed,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_accepted,
    output logic [afs_pkg::IDX_W-1:0]         o_current_frame,
    output logic                              o_frame_shown,
    output logic [afs_pkg::IDX_W-1:0]         o_slot_index,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic signed [afs_pkg::LOOP_W-1:0] i_cfg_data
);
    import afs_pkg::*;

    logic signed [LOOP_W-1:0] r_max_loops;
    logic                     r_out_valid;
    t_result                  r_out;

    t_request          req;
    t_result           seq_result;
    t_alu_req          alu_req;
    logic [TIME_W:0]   alu_res;
    t_mem_req          mem_req;
    t_frame            rd_data;
    logic              seq_idle;
    logic              seq_res_valid;
    logic              res_take;
    logic              start;

    assign req        = {i_command, i_frame_index, i_duration, i_visible, i_time_passed};
    assign o_in_ready = seq_idle;
    assign start      = i_in_valid && seq_idle;
    assign res_take   = seq_res_valid && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = 1'b1;

    // Hold the loop limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_loops <= '1;
        end else if (i_cfg_valid) begin
            r_max_loops <= i_cfg_data;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= seq_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_out.accepted;
    assign o_current_frame = r_out.current_frame;
    assign o_frame_shown   = r_out.frame_shown;
    assign o_slot_index    = r_out.slot_index;

    afs_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    afs_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    afs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_max_loops (r_max_loops),
        .o_idle      (seq_idle),
        .o_res_valid (seq_res_valid),
        .i_res_take  (res_take),
        .o_result    (seq_result),
        .o_alu       (alu_req),
        .i_alu_res   (alu_res),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data)
    );

endmodule

`default_nettype wire

FILE: design/afs_alu.sv
// Shared add/subtract unit with carry-out (borrow on subtract).
`default_nettype none

module afs_alu (
    input  afs_pkg::t_alu_req          i_req,
    output logic [afs_pkg::TIME_W:0]   o_res
);
    import afs_pkg::*;

    // Add or subtract one extended word; the top bit is carry or borrow
    always_comb begin
        unique case (i_req.op)
            ALU_ADD: o_res = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: o_res = {1'b0, i_req.a} - {1'b0, i_req.b};
            default: o_res = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/afs_frame_mem.sv
// Frame table memory: one write port, one registered read port.
`default_nettype none

module afs_frame_mem (
    input  logic              i_clk,
    input  afs_pkg::t_mem_req i_req,
    output afs_pkg::t_frame   o_rd_data
);
    import afs_pkg::*;

    t_frame r_mem [FRAMES];
    t_frame r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: design/afs_seq.sv
// Command sequencer: table bookkeeping, frame scan, stepping and modulo over the shared adder.
`default_nettype none

module afs_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  afs_pkg::t_request                 i_req,
    input  logic signed [afs_pkg::LOOP_W-1:0] i_max_loops,
    output logic                              o_idle,
    output logic                              o_res_valid,
    input  logic                              i_res_take,
    output afs_pkg::t_result                  o_result,
    output afs_pkg::t_alu_req                 o_alu,
    input  logic [afs_pkg::TIME_W:0]          i_alu_res,
    output afs_pkg::t_mem_req                 o_mem,
    input  afs_pkg::t_frame                   i_rd_data
);
    import afs_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UPD_SUB  = 4'd1;
    localparam logic [3:0] S_UPD_ADD  = 4'd2;
    localparam logic [3:0] S_SET_CHK  = 4'd3;
    localparam logic [3:0] S_TICK_RD  = 4'd4;
    localparam logic [3:0] S_ADV      = 4'd5;
    localparam logic [3:0] S_SCAN     = 4'd6;
    localparam logic [3:0] S_LOOP_CMP = 4'd7;
    localparam logic [3:0] S_MOD_CHK  = 4'd8;
    localparam logic [3:0] S_MOD_DEC  = 4'd9;
    localparam logic [3:0] S_MOD_STEP = 4'd10;
    localparam logic [3:0] S_MOD_FIN  = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0]        r_state,   n_state;
    t_request          r_req,     n_req;
    logic [CNT_W-1:0]  r_fiu,     n_fiu;
    logic [IDX_W-1:0]  r_active,  n_active;
    logic [TIME_W-1:0] r_time,    n_time;
    logic [LOOP_W-1:0] r_loops,   n_loops;
    logic [VT_W-1:0]   r_vtotal,  n_vtotal;
    logic [DUR_W-1:0]  r_cur_len, n_cur_len;
    logic              r_cur_vis, n_cur_vis;
    logic [IDX_W-1:0]  r_cand,    n_cand;
    logic [CNT_W-1:0]  r_pos,     n_pos;
    logic              r_prelude, n_prelude;
    logic              r_incd,    n_incd;
    logic              r_ret_done, n_ret_done;
    logic [VT_W-1:0]   r_div,     n_div;
    logic [VT_W-1:0]   r_rem,     n_rem;
    logic [STEP_W-1:0] r_step,    n_step;
    logic              r_acc,     n_acc;
    logic              r_shown,   n_shown;
    logic [IDX_W-1:0]  r_slot,    n_slot;

    logic              c_counted;
    logic              c_static;
    logic [LOOP_W-1:0] c_max_u;
    logic [LOOP_W-1:0] c_loop_inc;
    logic              c_borrow;
    logic              c_nonzero;
    logic              c_first_wrap;
    logic [IDX_W-1:0]  c_first_cand;
    logic              c_next_wrap;
    logic [IDX_W-1:0]  c_next_cand;
    logic              c_last;
    logic              c_idx_ok;
    logic              c_upd_ok;
    logic [VT_W:0]     c_rem_shift;

    // Decode loop mode and scan neighbors
    always_comb begin
        c_counted    = !i_max_loops[LOOP_W-1] && (i_max_loops != '0);
        c_static     = (i_max_loops == '0) || (r_vtotal == '0);
        c_max_u      = i_max_loops[LOOP_W-1:0];
        c_loop_inc   = r_loops + LOOP_W'(1);
        c_borrow     = i_alu_res[TIME_W];
        c_nonzero    = |i_alu_res[TIME_W-1:0];
        c_first_wrap = (CNT_W'(r_active) + CNT_W'(1)) == r_fiu;
        c_first_cand = c_first_wrap ? '0 : r_active + IDX_W'(1);
        c_next_wrap  = (CNT_W'(r_cand) + CNT_W'(1)) == r_fiu;
        c_next_cand  = c_next_wrap ? '0 : r_cand + IDX_W'(1);
        c_last       = r_pos == (r_fiu - CNT_W'(1));
        c_idx_ok     = CNT_W'(i_req.frame_index) < r_fiu;
        c_upd_ok     = r_fiu < CNT_W'(FRAMES);
        c_rem_shift  = {r_rem, r_time[TIME_W-1]};
    end

    // Drive the shared adder and the table ports
    always_comb begin
        o_alu.op        = ALU_ADD;
        o_alu.a         = r_time;
        o_alu.b         = '0;
        o_mem.wr_en     = 1'b0;
        o_mem.wr_addr   = r_fiu[IDX_W-1:0];
        o_mem.wr_data   = {i_req.duration, i_req.visible};
        o_mem.rd_addr   = r_cand;
        unique case (r_state)
            S_IDLE: begin
                o_alu.a = TIME_W'(r_vtotal);
                o_alu.b = i_req.visible ? TIME_W'(i_req.duration) : '0;
                o_mem.rd_addr = (i_req.command == CMD_TICK) ? r_active : i_req.frame_index;
                o_mem.wr_en = i_start && (i_req.command == CMD_APPEND) && c_upd_ok;
            end
            S_UPD_SUB: begin
                o_alu.op = ALU_SUB;
                o_alu.a  = TIME_W'(r_vtotal);
                o_alu.b  = i_rd_data.vis ? TIME_W'(i_rd_data.len) : '0;
            end
            S_UPD_ADD: begin
                o_alu.a       = TIME_W'(r_vtotal);
                o_alu.b       = r_req.visible ? TIME_W'(r_req.duration) : '0;
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = r_req.frame_index;
                o_mem.wr_data = {r_req.duration, r_req.visible};
            end
            S_TICK_RD: begin
                o_alu.b = TIME_W'(r_req.time_passed);
            end
            S_ADV: begin
                o_mem.rd_addr = c_first_cand;
            end
            S_SCAN: begin
                o_mem.rd_addr = c_next_cand;
            end
            S_LOOP_CMP: begin
                o_alu.op = ALU_SUB;
                o_alu.b  = TIME_W'(r_cur_len);
            end
            S_MOD_CHK: begin
                o_alu.op = ALU_SUB;
                o_alu.a  = TIME_W'(r_div);
                o_alu.b  = r_time;
            end
            S_MOD_DEC: begin
                o_alu.op = ALU_SUB;
                o_alu.b  = TIME_W'(1);
            end
            S_MOD_STEP: begin
                o_alu.op = ALU_SUB;
                o_alu.a  = TIME_W'(c_rem_shift);
                o_alu.b  = TIME_W'(r_div);
            end
            S_MOD_FIN: begin
                o_alu.a = TIME_W'(r_rem);
                o_alu.b = TIME_W'(1);
            end
            default: ;
        endcase
    end

    // Next-state and datapath updates
    always_comb begin
        logic adv_fail;
        logic adv_fallback;
        logic adv_found;

        adv_fail     = 1'b0;
        adv_fallback = 1'b0;
        adv_found    = 1'b0;
        n_state    = r_state;
        n_req      = r_req;
        n_fiu      = r_fiu;
        n_active   = r_active;
        n_time     = r_time;
        n_loops    = r_loops;
        n_vtotal   = r_vtotal;
        n_cur_len  = r_cur_len;
        n_cur_vis  = r_cur_vis;
        n_cand     = r_cand;
        n_pos      = r_pos;
        n_prelude  = r_prelude;
        n_incd     = r_incd;
        n_ret_done = r_ret_done;
        n_div      = r_div;
        n_rem      = r_rem;
        n_step     = r_step;
        n_acc      = r_acc;
        n_shown    = r_shown;
        n_slot     = r_slot;

        unique case (r_state)
            // Take a request and do the append and clear commands at once
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_acc   = 1'b0;
                    n_shown = 1'b0;
                    n_slot  = '0;
                    n_state = S_DONE;
                    unique case (i_req.command)
                        CMD_TICK: begin
                            n_acc   = 1'b1;
                            n_state = S_TICK_RD;
                        end
                        CMD_APPEND: begin
                            if (c_upd_ok) begin
                                n_acc    = 1'b1;
                                n_slot   = r_fiu[IDX_W-1:0];
                                n_fiu    = r_fiu + CNT_W'(1);
                                n_vtotal = i_alu_res[VT_W-1:0];
                            end
                        end
                        CMD_UPDATE: begin
                            if (c_idx_ok) begin
                                n_state = S_UPD_SUB;
                            end
                        end
                        CMD_SET: begin
                            if (c_idx_ok) begin
                                n_state = S_SET_CHK;
                            end
                        end
                        CMD_CLEAR: begin
                            n_acc    = 1'b1;
                            n_fiu    = '0;
                            n_active = '0;
                            n_time   = '0;
                            n_loops  = '0;
                            n_vtotal = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // Drop the old entry from the visible sum
            S_UPD_SUB: begin
                n_vtotal = i_alu_res[VT_W-1:0];
                n_state  = S_UPD_ADD;
            end
            // Add the new entry and rewrite it
            S_UPD_ADD: begin
                n_vtotal = i_alu_res[VT_W-1:0];
                n_acc    = 1'b1;
                n_state  = S_DONE;
            end
            // Select a visible frame only
            S_SET_CHK: begin
                if (i_rd_data.vis) begin
                    n_active = r_req.frame_index;
                    n_time   = '0;
                    n_acc    = 1'b1;
                end
                n_state = S_DONE;
            end
            // Load the current frame and accumulate time
            S_TICK_RD: begin
                n_cur_len = i_rd_data.len;
                n_cur_vis = i_rd_data.vis;
                n_prelude = 1'b0;
                if (c_static) begin
                    n_shown = (r_fiu != '0) && i_rd_data.vis;
                    n_state = S_DONE;
                end else begin
                    n_time = c_borrow ? TIME_MAX : i_alu_res[TIME_W-1:0];
                    if (!i_rd_data.vis) begin
                        n_prelude = 1'b1;
                        n_state   = S_ADV;
                    end else if (c_counted) begin
                        n_state = S_LOOP_CMP;
                    end else begin
                        n_div      = r_vtotal;
                        n_ret_done = 1'b0;
                        n_state    = S_MOD_CHK;
                    end
                end
            end
            // Start a search for the next visible frame
            S_ADV: begin
                n_incd = 1'b0;
                if (c_counted && (r_loops > c_max_u)) begin
                    adv_fail = 1'b1;
                end else if (r_fiu == CNT_W'(1)) begin
                    adv_fallback = 1'b1;
                end else begin
                    n_cand  = c_first_cand;
                    n_pos   = CNT_W'(1);
                    n_state = S_SCAN;
                    if (c_first_wrap && c_counted) begin
                        n_loops = c_loop_inc;
                        n_incd  = 1'b1;
                        if (c_loop_inc > c_max_u) begin
                            adv_fail = 1'b1;
                        end
                    end
                end
            end
            // Check one candidate per cycle, counting wraps
            S_SCAN: begin
                if (i_rd_data.vis) begin
                    adv_found = 1'b1;
                end else if (c_last) begin
                    adv_fallback = 1'b1;
                end else begin
                    n_cand = c_next_cand;
                    n_pos  = r_pos + CNT_W'(1);
                    if (c_next_wrap && c_counted) begin
                        n_loops = c_loop_inc;
                        n_incd  = 1'b1;
                        if (c_loop_inc > c_max_u) begin
                            adv_fail = 1'b1;
                        end
                    end
                end
            end
            // Step past a frame whose duration is used up
            S_LOOP_CMP: begin
                if (!c_borrow && c_nonzero) begin
                    n_time  = i_alu_res[TIME_W-1:0];
                    n_state = S_ADV;
                end else begin
                    n_shown = r_cur_vis;
                    n_state = S_DONE;
                end
            end
            // Reduce only when time exceeds the divisor
            S_MOD_CHK: begin
                if (c_borrow) begin
                    n_state = S_MOD_DEC;
                end else if (r_ret_done) begin
                    n_shown = r_cur_vis;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOOP_CMP;
                end
            end
            S_MOD_DEC: begin
                n_time  = i_alu_res[TIME_W-1:0];
                n_rem   = '0;
                n_step  = '0;
                n_state = S_MOD_STEP;
            end
            // Restoring remainder, one dividend bit a cycle
            S_MOD_STEP: begin
                n_rem  = c_borrow ? c_rem_shift[VT_W-1:0] : i_alu_res[VT_W-1:0];
                n_time = {r_time[TIME_W-2:0], 1'b0};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(TIME_W - 1)) begin
                    n_state = S_MOD_FIN;
                end
            end
            S_MOD_FIN: begin
                n_time = i_alu_res[TIME_W-1:0];
                if (r_ret_done) begin
                    n_shown = r_cur_vis;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOOP_CMP;
                end
            end
            // Hold the result until the output side takes it
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Resolve the outcome of a frame search
        if (adv_fail || (adv_fallback && !r_cur_vis)) begin
            if (r_prelude) begin
                n_time = '0;
            end
            n_shown = r_cur_vis;
            n_state = S_DONE;
        end else if (adv_fallback) begin
            if ((r_state == S_SCAN) && r_incd) begin
                n_state = S_LOOP_CMP;
            end else begin
                // Only this frame is visible and no wrap counts: fold the rest at once
                n_div      = VT_W'(r_cur_len);
                n_ret_done = 1'b1;
                n_state    = S_MOD_CHK;
            end
        end else if (adv_found) begin
            n_active  = r_cand;
            n_cur_len = i_rd_data.len;
            n_cur_vis = 1'b1;
            if (r_prelude) begin
                n_prelude = 1'b0;
                n_time    = TIME_W'(r_req.time_passed);
                if (c_counted) begin
                    n_state = S_LOOP_CMP;
                end else begin
                    n_div      = r_vtotal;
                    n_ret_done = 1'b0;
                    n_state    = S_MOD_CHK;
                end
            end else begin
                n_state = S_LOOP_CMP;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fiu    <= '0;
            r_active <= '0;
            r_time   <= '0;
            r_loops  <= '0;
            r_vtotal <= '0;
        end else begin
            r_state  <= n_state;
            r_fiu    <= n_fiu;
            r_active <= n_active;
            r_time   <= n_time;
            r_loops  <= n_loops;
            r_vtotal <= n_vtotal;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_cur_len  <= n_cur_len;
        r_cur_vis  <= n_cur_vis;
        r_cand     <= n_cand;
        r_pos      <= n_pos;
        r_prelude  <= n_prelude;
        r_incd     <= n_incd;
        r_ret_done <= n_ret_done;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_acc      <= n_acc;
        r_shown    <= n_shown;
        r_slot     <= n_slot;
    end

    assign o_idle      = r_state == S_IDLE;
    assign o_res_valid = r_state == S_DONE;
    assign o_result    = {r_acc, r_active, r_shown, r_slot};

    ap_active_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_fiu == '0) && (r_active == '0)) || (CNT_W'(r_active) < r_fiu))
        else $error("current frame outside the table");

    ap_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fiu <= CNT_W'(FRAMES))
        else $error("frame count beyond table size");

    ap_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD_STEP) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    ap_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_pos != '0) && (r_pos < r_fiu)))
        else $error("scan position outside candidate range");

    ap_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_state != S_IDLE))
        else $error("request taken but sequencer stayed idle");

endmodule

`default_nettype wire
